FILE: rtl/htc_pkg.sv
// Shared types and constants of the Huffman tree codec.
// No dependencies; imported by htc_ctrl, htc_dp and huffman_tree_codec_unit.
`default_nettype none

package htc_pkg;

  localparam int HTC_MAX_SYMBOLS = 64;
  localparam int HTC_WEIGHT_BITS = 16;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TABLE = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_SYM   = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_LD_POST, ST_LD_ERR,
    ST_BLD_TOP, ST_BS_RD, ST_BS_CMP, ST_MRG0, ST_MRG1, ST_MRG2,
    ST_CG_RP, ST_CG_WP, ST_CG_WC, ST_CG_EM,
    ST_ENC_RD, ST_ENC_CMP, ST_ENC_HIT, ST_ENC_MISS,
    ST_DEC_NXT, ST_DEC_LEAF, ST_DEC_SYM, ST_DEC_ERR, ST_DEC_END
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_LOAD,
    OP_ENC_INIT, OP_ENC_RD, OP_ENC_CT, OP_ENC_INC,
    OP_DEC_RDCUR, OP_DEC_NXT, OP_DEC_LEAF,
    OP_BLD_INIT, OP_SCAN_INIT, OP_BS_RD, OP_BS_CMP,
    OP_MRG0, OP_MRG1, OP_MRG2,
    OP_CG_INIT, OP_CG_RP, OP_CG_RC, OP_CG_STEP, OP_CG_SYM,
    OP_EM_LDERR, OP_EM_TABLE, OP_EM_ENC_HIT, OP_EM_ENC_MISS,
    OP_EM_DEC_ERR, OP_EM_DEC_SYM, OP_EM_END
  } dp_op_t;

  typedef struct packed {
    action_t act;
    logic    last;
    logic    built;
    logic    over;
    logic    out_free;
    logic    nxt_none;
    logic    is_leaf;
    logic    sym_match;
    logic    ei_last;
    logic    merge_done;
    logic    si_last;
    logic    cg_done;
    logic    gi_last;
  } htc_status_t;

endpackage

`default_nettype wire

FILE: rtl/htc_ctrl.sv
// Sequencer of the Huffman tree codec: one state machine issuing datapath ops.
// Depends on htc_pkg; drives htc_dp through dp_op_t and reads htc_status_t.
`default_nettype none

module htc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  htc_pkg::htc_status_t status_i,
  output htc_pkg::dp_op_t      op_o
);
  import htc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_o      = OP_NOP;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_o      = OP_ACCEPT;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.act)
          ACT_LOAD: begin
            op_o      = OP_LOAD;
            state_nxt = ST_LD_POST;
          end
          ACT_ENCODE: begin
            if (status_i.built) begin
              op_o      = OP_ENC_INIT;
              state_nxt = ST_ENC_RD;
            end else begin
              state_nxt = ST_ENC_MISS;
            end
          end
          ACT_DECODE: begin
            if (status_i.built) begin
              op_o      = OP_DEC_RDCUR;
              state_nxt = ST_DEC_NXT;
            end else begin
              state_nxt = ST_DEC_ERR;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_LD_POST: begin
        if (status_i.last) begin
          op_o      = OP_BLD_INIT;
          state_nxt = ST_BLD_TOP;
        end else if (status_i.over) begin
          state_nxt = ST_LD_ERR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LD_ERR: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_LDERR;
          state_nxt = ST_IDLE;
        end
      end
      ST_BLD_TOP: begin
        if (status_i.merge_done) begin
          op_o      = OP_CG_INIT;
          state_nxt = ST_CG_RP;
        end else begin
          op_o      = OP_SCAN_INIT;
          state_nxt = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        op_o      = OP_BS_RD;
        state_nxt = ST_BS_CMP;
      end
      ST_BS_CMP: begin
        op_o      = OP_BS_CMP;
        state_nxt = status_i.si_last ? ST_MRG0 : ST_BS_RD;
      end
      ST_MRG0: begin
        op_o      = OP_MRG0;
        state_nxt = ST_MRG1;
      end
      ST_MRG1: begin
        op_o      = OP_MRG1;
        state_nxt = ST_MRG2;
      end
      ST_MRG2: begin
        op_o      = OP_MRG2;
        state_nxt = ST_BLD_TOP;
      end
      ST_CG_RP: begin
        op_o      = OP_CG_RP;
        state_nxt = ST_CG_WP;
      end
      ST_CG_WP: begin
        if (status_i.cg_done) begin
          op_o      = OP_CG_SYM;
          state_nxt = ST_CG_EM;
        end else begin
          op_o      = OP_CG_RC;
          state_nxt = ST_CG_WC;
        end
      end
      ST_CG_WC: begin
        op_o      = OP_CG_STEP;
        state_nxt = ST_CG_RP;
      end
      ST_CG_EM: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_TABLE;
          state_nxt = status_i.gi_last ? ST_IDLE : ST_CG_RP;
        end
      end
      ST_ENC_RD: begin
        op_o      = OP_ENC_RD;
        state_nxt = ST_ENC_CMP;
      end
      ST_ENC_CMP: begin
        if (status_i.sym_match) begin
          op_o      = OP_ENC_CT;
          state_nxt = ST_ENC_HIT;
        end else begin
          op_o      = OP_ENC_INC;
          state_nxt = status_i.ei_last ? ST_ENC_MISS : ST_ENC_RD;
        end
      end
      ST_ENC_HIT: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_ENC_HIT;
          state_nxt = ST_IDLE;
        end
      end
      ST_ENC_MISS: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_ENC_MISS;
          state_nxt = ST_IDLE;
        end
      end
      ST_DEC_NXT: begin
        op_o      = OP_DEC_NXT;
        state_nxt = status_i.nxt_none ? ST_DEC_ERR : ST_DEC_LEAF;
      end
      ST_DEC_LEAF: begin
        op_o = OP_DEC_LEAF;
        if (status_i.is_leaf)    state_nxt = ST_DEC_SYM;
        else if (status_i.last)  state_nxt = ST_DEC_END;
        else                     state_nxt = ST_IDLE;
      end
      ST_DEC_SYM: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_DEC_SYM;
          state_nxt = status_i.last ? ST_DEC_END : ST_IDLE;
        end
      end
      ST_DEC_ERR: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_DEC_ERR;
          state_nxt = status_i.last ? ST_DEC_END : ST_IDLE;
        end
      end
      ST_DEC_END: begin
        if (status_i.out_free) begin
          op_o      = OP_EM_END;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/htc_dp.sv
// Datapath of the Huffman tree codec: node, leaf and code memories, counters,
// and the output register. Depends on htc_pkg; sequenced by htc_ctrl.
`default_nettype none

module htc_dp #(
  parameter int MAX_SYMBOLS = htc_pkg::HTC_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = htc_pkg::HTC_WEIGHT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  htc_pkg::dp_op_t      op_i,
  output htc_pkg::htc_status_t status_o,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_symbol,
  input  logic [15:0]          in_weight,
  input  logic                 in_bit_req,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_symbol_res,
  output logic [62:0]          out_code,
  output logic [5:0]           out_code_length,
  output logic                 out_error,
  output logic                 out_last_result
);
  import htc_pkg::*;

  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int NIW = $clog2(NODE_COUNT);
  localparam int NPW = NIW + 1;
  localparam int LIW = $clog2(MAX_SYMBOLS);
  localparam int CW  = $clog2(MAX_SYMBOLS + 1);
  localparam int WSW = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam logic [NPW-1:0] NONE  = '1;
  localparam logic [WSW-1:0] WMASK = WSW'({WEIGHT_BITS{1'b1}});

  // memories
  logic [WSW-1:0]   w_mem   [NODE_COUNT];
  logic [NPW-1:0]   par_mem [NODE_COUNT];
  logic [2*NPW-1:0] chd_mem [NODE_COUNT];   // {left, right}
  logic [7:0]       sym_mem [MAX_SYMBOLS];
  logic [68:0]      ct_mem  [MAX_SYMBOLS];  // {length, code}

  logic           w_we, w_re;
  logic [NIW-1:0] w_wa, w_ra;
  logic [WSW-1:0] w_wd, w_dout;
  logic           par_we, par_re;
  logic [NIW-1:0] par_wa, par_ra;
  logic [NPW-1:0] par_wd, par_dout;
  logic             chd_we, chd_re;
  logic [NIW-1:0]   chd_wa, chd_ra;
  logic [2*NPW-1:0] chd_wd, chd_dout;
  logic           sym_we, sym_re;
  logic [LIW-1:0] sym_wa, sym_ra;
  logic [7:0]     sym_wd, sym_dout;
  logic           ct_we, ct_re;
  logic [LIW-1:0] ct_wa, ct_ra;
  logic [68:0]    ct_wd, ct_dout;

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    if (w_re) w_dout <= w_mem[w_ra];
  end
  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_dout <= par_mem[par_ra];
  end
  always_ff @(posedge clk) begin
    if (chd_we) chd_mem[chd_wa] <= chd_wd;
    if (chd_re) chd_dout <= chd_mem[chd_ra];
  end
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa] <= sym_wd;
    if (sym_re) sym_dout <= sym_mem[sym_ra];
  end
  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_wa] <= ct_wd;
    if (ct_re) ct_dout <= ct_mem[ct_ra];
  end

  // control state
  logic [CW-1:0]  cnt_r;
  logic           built_r;
  logic [NIW-1:0] walk_r;
  logic           out_valid_r;

  // item and work registers
  action_t        act_r;
  logic [7:0]     sym_r;
  logic [WSW-1:0] wt_r;
  logic           bit_r, last_r;
  logic           over_r, bad_r, off_r;
  logic [LIW-1:0] ei_r, gi_r;
  logic [NIW-1:0] k_r, si_r, j_r;
  logic [NPW-1:0] lo_r, hi_r, nxt_r, p_r;
  logic [WSW-1:0] wlo_r, whi_r;
  logic [62:0]    code_r;
  logic [5:0]     len_r;

  logic [1:0]  okind_r;
  logic [7:0]  osym_r;
  logic [62:0] ocode_r;
  logic [5:0]  olen_r;
  logic        oerr_r, olast_r;

  logic [CW-1:0]  ce;
  logic           over_c;
  logic [NIW-1:0] root_c;
  logic [NPW-1:0] nxt_c;
  logic           nxt_none_c, leaf_c, gi_last_c, out_free_c;

  assign ce         = built_r ? '0 : cnt_r;
  assign over_c     = (ce >= CW'(MAX_SYMBOLS));
  assign root_c     = NIW'({cnt_r, 1'b0} - (CW + 1)'(2));
  assign nxt_c      = bit_r ? chd_dout[NPW-1:0] : chd_dout[2*NPW-1:NPW];
  assign nxt_none_c = (nxt_c == NONE);
  assign leaf_c     = (chd_dout == {NONE, NONE});
  assign gi_last_c  = (CW'(gi_r) == cnt_r - CW'(1));
  assign out_free_c = !out_valid_r || !out_stall;

  always_comb begin
    status_o            = '0;
    status_o.act        = act_r;
    status_o.last       = last_r;
    status_o.built      = built_r;
    status_o.over       = over_r;
    status_o.out_free   = out_free_c;
    status_o.nxt_none   = nxt_none_c;
    status_o.is_leaf    = leaf_c;
    status_o.sym_match  = (sym_dout == sym_r);
    status_o.ei_last    = (CW'(ei_r) == cnt_r - CW'(1));
    status_o.merge_done = ((NIW + 1)'(k_r) + (NIW + 1)'(1)) >= (NIW + 1)'({cnt_r, 1'b0});
    status_o.si_last    = (si_r == k_r - NIW'(1));
    status_o.cg_done    = (par_dout == NONE) || (len_r == 6'd63);
    status_o.gi_last    = gi_last_c;
  end

  // memory port selection
  always_comb begin
    w_we = 1'b0; w_re = 1'b0; w_wa = '0; w_ra = '0; w_wd = '0;
    par_we = 1'b0; par_re = 1'b0; par_wa = '0; par_ra = '0; par_wd = NONE;
    chd_we = 1'b0; chd_re = 1'b0; chd_wa = '0; chd_ra = '0; chd_wd = {NONE, NONE};
    sym_we = 1'b0; sym_re = 1'b0; sym_wa = '0; sym_ra = '0; sym_wd = sym_r;
    ct_we = 1'b0; ct_re = 1'b0; ct_wa = '0; ct_ra = '0; ct_wd = {len_r, code_r};
    case (op_i)
      OP_LOAD: begin
        if (!over_c) begin
          sym_we = 1'b1; sym_wa = ce[LIW-1:0];
          w_we   = 1'b1; w_wa   = NIW'(ce); w_wd = wt_r;
          par_we = 1'b1; par_wa = NIW'(ce);
          chd_we = 1'b1; chd_wa = NIW'(ce);
        end
      end
      OP_ENC_RD: begin
        sym_re = 1'b1; sym_ra = ei_r;
      end
      OP_ENC_CT: begin
        ct_re = 1'b1; ct_ra = ei_r;
      end
      OP_DEC_RDCUR: begin
        chd_re = 1'b1; chd_ra = walk_r;
      end
      OP_DEC_NXT: begin
        chd_re = 1'b1; chd_ra = nxt_c[NIW-1:0];
      end
      OP_DEC_LEAF: begin
        if (leaf_c) begin
          sym_re = 1'b1; sym_ra = nxt_r[LIW-1:0];
        end
      end
      OP_BS_RD: begin
        par_re = 1'b1; par_ra = si_r;
        w_re   = 1'b1; w_ra   = si_r;
      end
      OP_MRG0: begin
        chd_we = 1'b1; chd_wa = k_r; chd_wd = {lo_r, hi_r};
        par_we = 1'b1; par_wa = k_r;
        w_we   = 1'b1; w_wa   = k_r; w_wd = wlo_r + whi_r;
      end
      OP_MRG1: begin
        par_we = 1'b1; par_wa = lo_r[NIW-1:0]; par_wd = NPW'(k_r);
      end
      OP_MRG2: begin
        par_we = 1'b1; par_wa = hi_r[NIW-1:0]; par_wd = NPW'(k_r);
      end
      OP_CG_RP: begin
        par_re = 1'b1; par_ra = j_r;
      end
      OP_CG_RC: begin
        chd_re = 1'b1; chd_ra = par_dout[NIW-1:0];
      end
      OP_CG_SYM: begin
        sym_re = 1'b1; sym_ra = gi_r;
      end
      OP_EM_TABLE: begin
        ct_we = 1'b1; ct_wa = gi_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      built_r     <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op_i == OP_EM_LDERR || op_i == OP_EM_TABLE || op_i == OP_EM_ENC_HIT ||
          op_i == OP_EM_ENC_MISS || op_i == OP_EM_DEC_ERR ||
          op_i == OP_EM_DEC_SYM || op_i == OP_EM_END) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op_i)
        OP_LOAD: begin
          // a load after a build starts a fresh leaf set
          built_r <= 1'b0;
          if (built_r) walk_r <= '0;
          cnt_r <= over_c ? ce : ce + CW'(1);
        end
        OP_DEC_NXT: begin
          if (nxt_none_c) walk_r <= root_c;
        end
        OP_DEC_LEAF: begin
          walk_r <= leaf_c ? root_c : nxt_r[NIW-1:0];
        end
        OP_EM_TABLE: begin
          if (gi_last_c) begin
            built_r <= 1'b1;
            walk_r  <= root_c;
          end
        end
        OP_EM_END: begin
          if (built_r) walk_r <= root_c;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op_i)
      OP_ACCEPT: begin
        act_r  <= action_t'(in_action);
        sym_r  <= in_symbol;
        wt_r   <= WSW'(in_weight) & WMASK;
        bit_r  <= in_bit_req;
        last_r <= in_last;
        bad_r  <= 1'b0;
        off_r  <= 1'b0;
      end
      OP_LOAD:     over_r <= over_c;
      OP_ENC_INIT: ei_r <= '0;
      OP_ENC_INC:  ei_r <= ei_r + LIW'(1);
      OP_DEC_NXT: begin
        nxt_r <= nxt_c;
        if (nxt_none_c) bad_r <= 1'b1;
      end
      OP_DEC_LEAF: begin
        if (!leaf_c) off_r <= 1'b1;
      end
      OP_BLD_INIT: k_r <= NIW'(cnt_r);
      OP_SCAN_INIT: begin
        si_r <= '0;
        lo_r <= NONE;
        hi_r <= NONE;
      end
      OP_BS_CMP: begin
        // only free nodes compete; strict compares keep the lower index on ties
        if (par_dout == NONE) begin
          if (lo_r == NONE || w_dout < wlo_r) begin
            hi_r  <= lo_r;
            whi_r <= wlo_r;
            lo_r  <= NPW'(si_r);
            wlo_r <= w_dout;
          end else if (hi_r == NONE || w_dout < whi_r) begin
            hi_r  <= NPW'(si_r);
            whi_r <= w_dout;
          end
        end
        si_r <= si_r + NIW'(1);
      end
      OP_MRG2: k_r <= k_r + NIW'(1);
      OP_CG_INIT: begin
        gi_r   <= '0;
        j_r    <= '0;
        code_r <= '0;
        len_r  <= '0;
      end
      OP_CG_RC: p_r <= par_dout;
      OP_CG_STEP: begin
        // codes grow from the leaf up, so this bit lands at position len
        if (chd_dout[2*NPW-1:NPW] != NPW'(j_r)) code_r <= code_r | (63'(1) << len_r);
        len_r <= len_r + 6'd1;
        j_r   <= p_r[NIW-1:0];
      end
      OP_EM_TABLE: begin
        gi_r    <= gi_r + LIW'(1);
        j_r     <= NIW'(gi_r) + NIW'(1);
        code_r  <= '0;
        len_r   <= '0;
        okind_r <= KIND_TABLE;
        osym_r  <= sym_dout;
        ocode_r <= code_r;
        olen_r  <= len_r;
        oerr_r  <= over_r;
        olast_r <= gi_last_c;
      end
      OP_EM_LDERR: begin
        okind_r <= KIND_TABLE;
        osym_r  <= sym_r;
        ocode_r <= '0;
        olen_r  <= '0;
        oerr_r  <= 1'b1;
        olast_r <= 1'b1;
      end
      OP_EM_ENC_HIT: begin
        okind_r <= KIND_CODE;
        osym_r  <= sym_r;
        ocode_r <= ct_dout[62:0];
        olen_r  <= ct_dout[68:63];
        oerr_r  <= 1'b0;
        olast_r <= 1'b1;
      end
      OP_EM_ENC_MISS: begin
        okind_r <= KIND_CODE;
        osym_r  <= sym_r;
        ocode_r <= '0;
        olen_r  <= '0;
        oerr_r  <= 1'b1;
        olast_r <= 1'b1;
      end
      OP_EM_DEC_ERR: begin
        okind_r <= KIND_SYM;
        osym_r  <= '0;
        ocode_r <= '0;
        olen_r  <= '0;
        oerr_r  <= 1'b1;
        olast_r <= !last_r;
      end
      OP_EM_DEC_SYM: begin
        okind_r <= KIND_SYM;
        osym_r  <= sym_dout;
        ocode_r <= '0;
        olen_r  <= '0;
        oerr_r  <= 1'b0;
        olast_r <= !last_r;
      end
      OP_EM_END: begin
        okind_r <= KIND_END;
        osym_r  <= '0;
        ocode_r <= '0;
        olen_r  <= '0;
        oerr_r  <= bad_r || off_r || !built_r;
        olast_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = okind_r;
  assign out_symbol_res  = osym_r;
  assign out_code        = ocode_r;
  assign out_code_length = olen_r;
  assign out_error       = oerr_r;
  assign out_last_result = olast_r;

endmodule

`default_nettype wire

FILE: rtl/huffman_tree_codec_unit.sv
// Top level of the Huffman tree codec: sequencer plus datapath.
// Depends on htc_pkg, htc_ctrl and htc_dp.
`default_nettype none

// Loads (symbol, weight) leaves; the load beat marked last builds the tree and
// returns one table entry per leaf in load order. Encode beats return a code
// or an error, decode beats walk one bit from the current node. One item is
// worked at a time; in_stall is high after acceptance until the item is done
// and its last result, if any, is in the output register. The build is a
// sequential scan of the node memory for each merge, then code generation
// walks each leaf up to the root. Results wait for out_stall only at the
// output register.
module huffman_tree_codec_unit #(
  parameter int MAX_SYMBOLS = htc_pkg::HTC_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = htc_pkg::HTC_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_weight,
  input  logic        in_bit_req,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_symbol_res,
  output logic [62:0] out_code,
  output logic [5:0]  out_code_length,
  output logic        out_error,
  output logic        out_last_result
);
  import htc_pkg::*;

  dp_op_t      op;
  htc_status_t status;

  htc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status_i (status),
    .op_o     (op)
  );

  htc_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_i            (op),
    .status_o        (status),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_weight       (in_weight),
    .in_bit_req      (in_bit_req),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_symbol_res  (out_symbol_res),
    .out_code        (out_code),
    .out_code_length (out_code_length),
    .out_error       (out_error),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire
